@@ rtl/mi_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared word width, request/response types, sequencer states and codes.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int MI_WIDTH = 16;
    localparam int MI_CNT_W = $clog2(MI_WIDTH);

    typedef logic [MI_WIDTH-1:0] t_word;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        t_word value;
        t_word modulus;
    } t_mi_req;

    typedef struct packed {
        t_word inverse;
        logic  status;
    } t_mi_rsp;

    // working set of the shift-subtract divider with coefficient accumulate
    typedef struct packed {
        t_word part;
        t_word dvd;
        t_word acc;
    } t_mi_div;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_DIV    = 6'b000100,
        S_UPDATE = 6'b001000,
        S_FIX    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

endpackage

@@ rtl/modular_inverse_top.sv @@
// ----------------------------------------------------------------------------
// Modular inverse top level
// Extended Euclid inverse with one shared bit-serial divide step unit.
//
// Channel   Direction  Handshake       Payload
// request   in         start, busy     i_req  (value, modulus)
// response  out        o_done strobe   o_rsp  (inverse, status)
//
// Each Euclid round runs MI_WIDTH divide steps in the shared step unit, one
// coefficient update and one loop test. Trivial operands (value or modulus
// one, zero operand) are answered straight from idle, without a round.
// Reset is synchronous and active low; no clearing pass is needed.
// busy is high while a request is at work; the response is never stalled.
// ----------------------------------------------------------------------------
module modular_inverse_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  mi_pkg::t_mi_req i_req,
    output logic            o_done,
    output mi_pkg::t_mi_rsp o_rsp
);
    import mi_pkg::*;

    t_state              r_state;
    t_word               r_mod;
    t_word               r_cur;
    t_word               r_rem;
    t_word               r_keep;
    t_word               r_next;
    logic                r_neg;
    t_mi_div             r_div;
    logic [MI_CNT_W-1:0] r_cnt;
    logic                r_done;
    t_mi_rsp             r_rsp;

    t_mi_div             n_div;
    t_word               n_fix;
    t_word               n_out;

    mi_div_step u_step (
        .i_cur     (r_div),
        .i_divisor (r_rem),
        .i_mult    (r_next),
        .o_nxt     (n_div)
    );

    always_comb begin
        n_fix = (r_neg && (r_keep != '0)) ? (r_mod - r_keep) : r_keep;
        n_out = (r_keep >= r_mod) ? (r_keep - r_mod) : r_keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mod  <= i_req.modulus;
                        r_cur  <= i_req.value;
                        r_rem  <= i_req.modulus;
                        r_keep <= t_word'(1);
                        r_next <= '0;
                        r_neg  <= 1'b0;
                        if (i_req.modulus == t_word'(1) || i_req.value == t_word'(1)) begin
                            r_rsp  <= '{inverse: t_word'(1), status: ST_OK};
                            r_done <= 1'b1;
                        end else if (i_req.value == '0 || i_req.modulus == '0) begin
                            r_rsp  <= '{inverse: '0, status: ST_FAIL};
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_cur == '0 || (r_cur > t_word'(1) && r_rem == '0)) begin
                        r_rsp   <= '{inverse: '0, status: ST_FAIL};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_cur == t_word'(1)) begin
                        r_state <= S_FIX;
                    end else begin
                        r_div   <= '{part: '0, dvd: r_cur, acc: '0};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div <= n_div;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MI_CNT_W'(MI_WIDTH - 1)) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_cur   <= r_rem;
                    r_rem   <= r_div.part;
                    r_keep  <= r_next;
                    r_next  <= r_keep + r_div.acc;
                    r_neg   <= ~r_neg;
                    r_state <= S_CHECK;
                end
                S_FIX: begin
                    r_keep  <= n_fix;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_rsp   <= '{inverse: n_out, status: ST_OK};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response strobe while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FAIL) |-> (o_rsp.inverse == '0))
        else $error("failed request with nonzero inverse");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_OK && r_mod > t_word'(1)) |-> (o_rsp.inverse < r_mod))
        else $error("inverse not reduced below modulus");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request dropped");

endmodule

@@ rtl/mi_div_step.sv @@
// ----------------------------------------------------------------------------
// Modular inverse divide step
// One restoring division step; the quotient bit is folded into the
// coefficient product by shift-and-add.
// ----------------------------------------------------------------------------
module mi_div_step (
    input  mi_pkg::t_mi_div i_cur,
    input  mi_pkg::t_word   i_divisor,
    input  mi_pkg::t_word   i_mult,
    output mi_pkg::t_mi_div o_nxt
);
    import mi_pkg::*;

    logic [MI_WIDTH:0] ext;
    logic [MI_WIDTH:0] diff;
    logic              take;

    always_comb begin
        ext   = {i_cur.part, i_cur.dvd[MI_WIDTH-1]};
        diff  = ext - {1'b0, i_divisor};
        take  = (ext >= {1'b0, i_divisor});
        o_nxt.part = take ? diff[MI_WIDTH-1:0] : ext[MI_WIDTH-1:0];
        o_nxt.dvd  = {i_cur.dvd[MI_WIDTH-2:0], 1'b0};
        o_nxt.acc  = {i_cur.acc[MI_WIDTH-2:0], 1'b0} + (take ? i_mult : '0);
    end

endmodule
